// ===== sv/bfs_pkg.sv =====
// ----------------------------------------------------------------------------
// bfs_pkg
// Shared types, constants and helpers for the boids flock step unit.
// ----------------------------------------------------------------------------
package bfs_pkg;

  localparam int MAX_BOIDS = 64;
  localparam int IDX_W     = 6;
  localparam int CNT_W     = 7;

  // iteration counts of the serial divider
  localparam logic [CNT_W-1:0] MEAN_STEPS = 7'd39;
  localparam logic [CNT_W-1:0] PAIR_STEPS = 7'd33;

  // register reset values
  localparam logic [6:0]  RST_FLOCK_SIZE = 7'd64;
  localparam logic [30:0] RST_RADIUS     = 31'd6554;
  localparam logic [15:0] RST_TIME_STEP  = 16'd1092;
  localparam logic [15:0] RST_COH_GAIN   = 16'd655;
  localparam logic [15:0] RST_SEP_GAIN   = 16'd32768;
  localparam logic [15:0] RST_ALIGN_GAIN = 16'd13107;

  localparam logic signed [35:0] FX_MAX_EXT = 36'sd2147483647;
  localparam logic signed [35:0] FX_MIN_EXT = -36'sd2147483648;

  typedef enum logic [2:0] {
    REG_FLOCK_SIZE = 3'd0,
    REG_RADIUS     = 3'd1,
    REG_TIME_STEP  = 3'd2,
    REG_COH_GAIN   = 3'd3,
    REG_SEP_GAIN   = 3'd4,
    REG_ALIGN_GAIN = 3'd5
  } bfs_reg_t;

  typedef struct packed {
    logic               mode;
    logic [IDX_W-1:0]   boid_index;
    logic signed [31:0] load_pos_x;
    logic signed [31:0] load_pos_y;
    logic signed [31:0] load_vel_x;
    logic signed [31:0] load_vel_y;
  } bfs_in_t;

  typedef struct packed {
    logic [IDX_W-1:0]   out_index;
    logic signed [31:0] new_pos_x;
    logic signed [31:0] new_pos_y;
    logic signed [31:0] new_vel_x;
    logic signed [31:0] new_vel_y;
    logic               last_boid;
    logic               saturated;
  } bfs_out_t;

  typedef struct packed {
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] vx;
    logic signed [31:0] vy;
  } bfs_entry_t;

  typedef struct packed {
    logic [30:0] neighbor_radius;
    logic [15:0] time_step;
    logic [15:0] cohesion_gain;
    logic [15:0] separation_gain;
    logic [15:0] alignment_gain;
  } bfs_cfg_t;

  typedef enum logic [4:0] {
    OP_NONE, OP_LOAD, OP_SUM_CLR, OP_SUM_ACC, OP_MP_DIV, OP_MP_SET, OP_MV_DIV,
    OP_MV_SET, OP_AL_SCL, OP_AL_SET, OP_OWN, OP_DIFF, OP_SQ, OP_D2, OP_PR_DIV,
    OP_PR_ACC, OP_SM_DIV, OP_SM_SET, OP_SEP_SCL, OP_COH_SCL, OP_ACC, OP_VEL_SCL,
    OP_VEL, OP_POS_SCL, OP_POS, OP_EMIT, OP_COPY
  } bfs_op_t;

  typedef struct packed {
    bfs_op_t          op;
    logic [IDX_W-1:0] addr;
    logic             last;
    logic [CNT_W-1:0] count;
  } bfs_cmd_t;

  typedef struct packed {
    logic nbr;
    logic cnt_zero;
    logic div_done;
  } bfs_stat_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_SUM_RD, ST_SUM_ACC, ST_MP_DIV, ST_MP_WAIT, ST_MV_DIV, ST_MV_WAIT,
    ST_AL_SCL, ST_AL_SET, ST_OWN_RD, ST_OWN, ST_PR_RD, ST_PR_DIFF, ST_PR_SQ,
    ST_PR_D2, ST_PR_CHK, ST_PR_WAIT, ST_SM_DIV, ST_SM_WAIT, ST_SM_SET,
    ST_SEP_SCL, ST_COH_SCL, ST_ACC, ST_VEL_SCL, ST_VEL, ST_POS_SCL, ST_POS,
    ST_EMIT, ST_CP_RD, ST_CP_WR
  } bfs_state_t;

  // magnitude of a 39-bit signed sum
  function automatic logic [38:0] mag39(input logic signed [38:0] a);
    logic [38:0] r;
    r = a[38] ? 39'(-a) : 39'(a);
    return r;
  endfunction

  // magnitude of a 33-bit signed operand
  function automatic logic [32:0] mag33(input logic signed [32:0] a);
    logic [32:0] r;
    r = a[32] ? 33'(-a) : 33'(a);
    return r;
  endfunction

  // put a sign back on a 32-bit quotient magnitude
  function automatic logic signed [31:0] apply_sign(input logic neg, input logic [31:0] q);
    logic signed [32:0] t;
    t = $signed({1'b0, q});
    t = neg ? -t : t;
    return t[31:0];
  endfunction

  // clip to the signed 32-bit range
  function automatic logic signed [31:0] clip_fx(input logic signed [35:0] v);
    logic signed [35:0] r;
    r = v;
    if (v > FX_MAX_EXT) r = FX_MAX_EXT;
    if (v < FX_MIN_EXT) r = FX_MIN_EXT;
    return r[31:0];
  endfunction

  function automatic logic clip_hit(input logic signed [35:0] v);
    return (v > FX_MAX_EXT) || (v < FX_MIN_EXT);
  endfunction

endpackage

// ===== sv/bfs_div.sv =====
// ----------------------------------------------------------------------------
// bfs_div
// Serial restoring divider, one quotient bit per cycle. The partial
// remainder starts at rem_init and dividend bits are shifted in MSB first.
// ----------------------------------------------------------------------------
module bfs_div
  import bfs_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [63:0]      rem_init,
  input  logic [63:0]      dvd,
  input  logic [62:0]      dvs,
  input  logic [CNT_W-1:0] steps,
  output logic             done,
  output logic [63:0]      quo
);

  logic             run;
  logic [CNT_W-1:0] cnt;
  logic [63:0]      rem;
  logic [63:0]      dvd_r;
  logic [62:0]      dvs_r;
  logic [63:0]      rem_sh;
  logic [63:0]      rem_sub;
  logic             ge;

  // one trial subtraction
  always_comb begin
    rem_sh  = {rem[62:0], dvd_r[63]};
    ge      = rem_sh >= {1'b0, dvs_r};
    rem_sub = rem_sh - {1'b0, dvs_r};
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      run  <= 1'b1;
      done <= 1'b0;
      cnt  <= steps;
    end else if (run) begin
      cnt <= cnt - 7'd1;
      if (cnt == 7'd1) begin
        run  <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= rem_init;
      dvd_r <= dvd;
      dvs_r <= dvs;
      quo   <= '0;
    end else if (run) begin
      rem   <= ge ? rem_sub : rem_sh;
      dvd_r <= {dvd_r[62:0], 1'b0};
      quo   <= {quo[62:0], ge};
    end
  end

endmodule

// ===== sv/bfs_datapath.sv =====
// ----------------------------------------------------------------------------
// bfs_datapath
// Flock store, snapshot buffer, means, pair separation, gain scaling and
// integration. Each cycle performs the operation named by the controller.
// ----------------------------------------------------------------------------
module bfs_datapath
  import bfs_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  bfs_cmd_t  ctl,
  input  bfs_in_t   cmd_in,
  input  bfs_cfg_t  cfg,
  output bfs_stat_t stat,
  output logic      result_valid,
  output bfs_out_t  result
);

  bfs_entry_t main_mem   [MAX_BOIDS];
  bfs_entry_t shadow_mem [MAX_BOIDS];
  bfs_entry_t rd_main;
  bfs_entry_t rd_shadow;

  logic signed [38:0] spx, spy, svx, svy;
  logic        [61:0] r2;
  logic signed [31:0] mpx, mpy, mvx, mvy, avx, avy;
  logic signed [31:0] ox, oy, ovx, ovy;
  logic signed [38:0] sx, sy;
  logic [CNT_W-1:0]   cnt;
  logic        [30:0] mx, my;
  logic               farx, fary, sgnx, sgny;
  logic        [61:0] mx2, my2;
  logic               nbr;
  logic signed [31:0] smx, smy, sepx, sepy;
  logic        [48:0] prod_x, prod_y;
  logic               neg_x, neg_y;
  logic signed [31:0] ax, ay, vx, vy, px, py;
  logic               flag;

  // divider hookup
  logic               div_start;
  logic        [63:0] rem_x, rem_y, dvd_x, dvd_y, quo_x, quo_y;
  logic        [62:0] dvs;
  logic [CNT_W-1:0]   steps;
  logic               done_x, done_y;

  // comb helpers
  logic signed [32:0] dx, dy;
  logic        [32:0] adx, ady;
  logic        [62:0] d2_sum;
  logic        [32:0] qx33, qy33;
  logic               hit_x, hit_y;
  logic        [30:0] qcx, qcy;
  logic signed [38:0] term_x, term_y;
  logic signed [32:0] opx, opy;
  logic        [15:0] gain;
  logic signed [33:0] scl_x, scl_y;
  logic signed [35:0] sum_x, sum_y;

  // flock store and snapshot buffer
  always_ff @(posedge clk) begin
    if (ctl.op == OP_LOAD) begin
      main_mem[cmd_in.boid_index] <= {cmd_in.load_pos_x, cmd_in.load_pos_y,
                                      cmd_in.load_vel_x, cmd_in.load_vel_y};
    end else if (ctl.op == OP_COPY) begin
      main_mem[ctl.addr] <= rd_shadow;
    end
    rd_main <= main_mem[ctl.addr];
  end

  always_ff @(posedge clk) begin
    if (ctl.op == OP_EMIT) begin
      shadow_mem[ctl.addr] <= {px, py, vx, vy};
    end
    rd_shadow <= shadow_mem[ctl.addr];
  end

  // divider operand selection
  always_comb begin
    div_start = 1'b0;
    rem_x     = '0;
    rem_y     = '0;
    dvd_x     = '0;
    dvd_y     = '0;
    dvs       = '0;
    steps     = MEAN_STEPS;
    case (ctl.op)
      OP_MP_DIV: begin
        div_start = 1'b1;
        dvd_x     = {mag39(spx), 25'b0};
        dvd_y     = {mag39(spy), 25'b0};
        dvs       = {56'b0, ctl.count};
      end
      OP_MV_DIV: begin
        div_start = 1'b1;
        dvd_x     = {mag39(svx), 25'b0};
        dvd_y     = {mag39(svy), 25'b0};
        dvs       = {56'b0, ctl.count};
      end
      OP_PR_DIV: begin
        div_start = 1'b1;
        rem_x     = {34'b0, mx[30:1]};
        rem_y     = {34'b0, my[30:1]};
        dvd_x     = {mx[0], 63'b0};
        dvd_y     = {my[0], 63'b0};
        dvs       = {1'b0, mx2} + {1'b0, my2};
        steps     = PAIR_STEPS;
      end
      OP_SM_DIV: begin
        div_start = 1'b1;
        dvd_x     = {mag39(sx), 25'b0};
        dvd_y     = {mag39(sy), 25'b0};
        dvs       = {56'b0, cnt};
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  bfs_div u_div_x (
    .clk(clk), .rst(rst), .start(div_start), .rem_init(rem_x), .dvd(dvd_x),
    .dvs(dvs), .steps(steps), .done(done_x), .quo(quo_x)
  );

  bfs_div u_div_y (
    .clk(clk), .rst(rst), .start(div_start), .rem_init(rem_y), .dvd(dvd_y),
    .dvs(dvs), .steps(steps), .done(done_y), .quo(quo_y)
  );

  // pair terms
  always_comb begin
    dx     = {ox[31], ox} - {rd_main.px[31], rd_main.px};
    dy     = {oy[31], oy} - {rd_main.py[31], rd_main.py};
    adx    = mag33(dx);
    ady    = mag33(dy);
    d2_sum = {1'b0, mx2} + {1'b0, my2};
    qx33   = quo_x[32:0];
    qy33   = quo_y[32:0];
    hit_x  = qx33[32] | qx33[31];
    hit_y  = qy33[32] | qy33[31];
    qcx    = hit_x ? 31'h7fffffff : qx33[30:0];
    qcy    = hit_y ? 31'h7fffffff : qy33[30:0];
    term_x = sgnx ? -$signed({8'b0, qcx}) : $signed({8'b0, qcx});
    term_y = sgny ? -$signed({8'b0, qcy}) : $signed({8'b0, qcy});
  end

  // scaling operand selection
  always_comb begin
    opx  = '0;
    opy  = '0;
    gain = '0;
    case (ctl.op)
      OP_AL_SCL: begin
        opx  = {mvx[31], mvx};
        opy  = {mvy[31], mvy};
        gain = cfg.alignment_gain;
      end
      OP_SEP_SCL: begin
        opx  = {smx[31], smx};
        opy  = {smy[31], smy};
        gain = cfg.separation_gain;
      end
      OP_COH_SCL: begin
        opx  = {mpx[31], mpx} - {ox[31], ox};
        opy  = {mpy[31], mpy} - {oy[31], oy};
        gain = cfg.cohesion_gain;
      end
      OP_VEL_SCL: begin
        opx  = {ax[31], ax};
        opy  = {ay[31], ay};
        gain = cfg.time_step;
      end
      OP_POS_SCL: begin
        opx  = {vx[31], vx};
        opy  = {vy[31], vy};
        gain = cfg.time_step;
      end
      default: begin
        gain = '0;
      end
    endcase
  end

  // scaled value, truncated toward zero
  always_comb begin
    scl_x = neg_x ? -$signed({1'b0, prod_x[48:16]}) : $signed({1'b0, prod_x[48:16]});
    scl_y = neg_y ? -$signed({1'b0, prod_y[48:16]}) : $signed({1'b0, prod_y[48:16]});
  end

  // sums for acceleration, velocity and position
  always_comb begin
    case (ctl.op)
      OP_ACC: begin
        sum_x = {{2{scl_x[33]}}, scl_x} + {{4{sepx[31]}}, sepx} + {{4{avx[31]}}, avx};
        sum_y = {{2{scl_y[33]}}, scl_y} + {{4{sepy[31]}}, sepy} + {{4{avy[31]}}, avy};
      end
      OP_VEL: begin
        sum_x = {{4{ovx[31]}}, ovx} + {{2{scl_x[33]}}, scl_x};
        sum_y = {{4{ovy[31]}}, ovy} + {{2{scl_y[33]}}, scl_y};
      end
      default: begin
        sum_x = {{4{ox[31]}}, ox} + {{2{scl_x[33]}}, scl_x};
        sum_y = {{4{oy[31]}}, oy} + {{2{scl_y[33]}}, scl_y};
      end
    endcase
  end

  // working registers
  always_ff @(posedge clk) begin
    prod_x <= 49'(mag33(opx)) * 49'(gain);
    prod_y <= 49'(mag33(opy)) * 49'(gain);
    neg_x  <= opx[32];
    neg_y  <= opy[32];
    case (ctl.op)
      OP_SUM_CLR: begin
        spx <= '0;
        spy <= '0;
        svx <= '0;
        svy <= '0;
        r2  <= 62'(cfg.neighbor_radius) * 62'(cfg.neighbor_radius);
      end
      OP_SUM_ACC: begin
        spx <= spx + {{7{rd_main.px[31]}}, rd_main.px};
        spy <= spy + {{7{rd_main.py[31]}}, rd_main.py};
        svx <= svx + {{7{rd_main.vx[31]}}, rd_main.vx};
        svy <= svy + {{7{rd_main.vy[31]}}, rd_main.vy};
      end
      OP_MP_SET: begin
        mpx <= apply_sign(spx[38], quo_x[31:0]);
        mpy <= apply_sign(spy[38], quo_y[31:0]);
      end
      OP_MV_SET: begin
        mvx <= apply_sign(svx[38], quo_x[31:0]);
        mvy <= apply_sign(svy[38], quo_y[31:0]);
      end
      OP_AL_SET: begin
        avx <= scl_x[31:0];
        avy <= scl_y[31:0];
      end
      OP_OWN: begin
        ox   <= rd_main.px;
        oy   <= rd_main.py;
        ovx  <= rd_main.vx;
        ovy  <= rd_main.vy;
        sx   <= '0;
        sy   <= '0;
        cnt  <= '0;
        flag <= 1'b0;
      end
      OP_DIFF: begin
        mx   <= adx[30:0];
        my   <= ady[30:0];
        farx <= adx[32] | adx[31];
        fary <= ady[32] | ady[31];
        sgnx <= dx[32];
        sgny <= dy[32];
      end
      OP_SQ: begin
        mx2 <= 62'(mx) * 62'(mx);
        my2 <= 62'(my) * 62'(my);
      end
      OP_D2: begin
        nbr <= !farx && !fary && (d2_sum != '0) && (d2_sum < {1'b0, r2});
      end
      OP_PR_ACC: begin
        sx   <= sx + term_x;
        sy   <= sy + term_y;
        cnt  <= cnt + 7'd1;
        flag <= flag | hit_x | hit_y;
      end
      OP_SM_SET: begin
        smx <= (cnt == '0) ? '0 : apply_sign(sx[38], quo_x[31:0]);
        smy <= (cnt == '0) ? '0 : apply_sign(sy[38], quo_y[31:0]);
      end
      OP_COH_SCL: begin
        sepx <= scl_x[31:0];
        sepy <= scl_y[31:0];
      end
      OP_ACC: begin
        ax   <= clip_fx(sum_x);
        ay   <= clip_fx(sum_y);
        flag <= flag | clip_hit(sum_x) | clip_hit(sum_y);
      end
      OP_VEL: begin
        vx   <= clip_fx(sum_x);
        vy   <= clip_fx(sum_y);
        flag <= flag | clip_hit(sum_x) | clip_hit(sum_y);
      end
      OP_POS: begin
        px   <= clip_fx(sum_x);
        py   <= clip_fx(sum_y);
        flag <= flag | clip_hit(sum_x) | clip_hit(sum_y);
      end
      default: begin
        nbr <= nbr;
      end
    endcase
  end

  // result register, result_valid high for a single cycle per emitted item
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= (ctl.op == OP_EMIT);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.op == OP_EMIT) begin
      result <= {ctl.addr, px, py, vx, vy, ctl.last, flag};
    end
  end

  // status to the controller
  assign stat.nbr      = nbr;
  assign stat.cnt_zero = (cnt == '0);
  assign stat.div_done = done_x & done_y;

endmodule

// ===== sv/bfs_ctrl.sv =====
// ----------------------------------------------------------------------------
// bfs_ctrl
// Sequencer for load and step items: mean pass, per-boid pair loop,
// per-boid update and the final copy of the snapshot back to the store.
// ----------------------------------------------------------------------------
module bfs_ctrl
  import bfs_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic             mode,
  input  logic [6:0]       flock_size,
  input  bfs_stat_t        stat,
  output bfs_cmd_t         ctl,
  output logic             busy
);

  bfs_state_t       state, state_next;
  logic [IDX_W-1:0] i, i_next;
  logic [IDX_W-1:0] j, j_next;
  logic [CNT_W-1:0] count;
  logic [IDX_W-1:0] last_idx;
  logic             j_last, i_last;

  // effective flock size, clamped to 1 .. MAX_BOIDS
  always_comb begin
    if (flock_size == '0) begin
      count = 7'd1;
    end else if (flock_size > 7'(MAX_BOIDS)) begin
      count = 7'(MAX_BOIDS);
    end else begin
      count = flock_size;
    end
    last_idx = 6'(count - 7'd1);
    j_last   = (j == last_idx);
    i_last   = (i == last_idx);
  end

  assign busy = (state != ST_IDLE);

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      i     <= '0;
      j     <= '0;
    end else begin
      state <= state_next;
      i     <= i_next;
      j     <= j_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next = state;
    i_next     = i;
    j_next     = j;
    ctl.op     = OP_NONE;
    ctl.addr   = j;
    ctl.last   = 1'b0;
    ctl.count  = count;
    case (state)
      ST_IDLE: begin
        if (start && !mode) begin
          ctl.op = OP_LOAD;
        end else if (start) begin
          ctl.op     = OP_SUM_CLR;
          j_next     = '0;
          state_next = ST_SUM_RD;
        end
      end
      ST_SUM_RD: state_next = ST_SUM_ACC;
      ST_SUM_ACC: begin
        ctl.op = OP_SUM_ACC;
        if (j_last) begin
          state_next = ST_MP_DIV;
        end else begin
          j_next     = j + 6'd1;
          state_next = ST_SUM_RD;
        end
      end
      ST_MP_DIV: begin
        ctl.op     = OP_MP_DIV;
        state_next = ST_MP_WAIT;
      end
      ST_MP_WAIT: begin
        if (stat.div_done) begin
          ctl.op     = OP_MP_SET;
          state_next = ST_MV_DIV;
        end
      end
      ST_MV_DIV: begin
        ctl.op     = OP_MV_DIV;
        state_next = ST_MV_WAIT;
      end
      ST_MV_WAIT: begin
        if (stat.div_done) begin
          ctl.op     = OP_MV_SET;
          state_next = ST_AL_SCL;
        end
      end
      ST_AL_SCL: begin
        ctl.op     = OP_AL_SCL;
        state_next = ST_AL_SET;
      end
      ST_AL_SET: begin
        ctl.op     = OP_AL_SET;
        i_next     = '0;
        state_next = ST_OWN_RD;
      end
      ST_OWN_RD: begin
        ctl.addr   = i;
        state_next = ST_OWN;
      end
      ST_OWN: begin
        ctl.op     = OP_OWN;
        j_next     = '0;
        state_next = ST_PR_RD;
      end
      ST_PR_RD: state_next = ST_PR_DIFF;
      ST_PR_DIFF: begin
        ctl.op     = OP_DIFF;
        state_next = ST_PR_SQ;
      end
      ST_PR_SQ: begin
        ctl.op     = OP_SQ;
        state_next = ST_PR_D2;
      end
      ST_PR_D2: begin
        ctl.op     = OP_D2;
        state_next = ST_PR_CHK;
      end
      ST_PR_CHK: begin
        if (stat.nbr) begin
          ctl.op     = OP_PR_DIV;
          state_next = ST_PR_WAIT;
        end else if (j_last) begin
          state_next = ST_SM_DIV;
        end else begin
          j_next     = j + 6'd1;
          state_next = ST_PR_RD;
        end
      end
      ST_PR_WAIT: begin
        if (stat.div_done) begin
          ctl.op = OP_PR_ACC;
          if (j_last) begin
            state_next = ST_SM_DIV;
          end else begin
            j_next     = j + 6'd1;
            state_next = ST_PR_RD;
          end
        end
      end
      ST_SM_DIV: begin
        if (stat.cnt_zero) begin
          state_next = ST_SM_SET;
        end else begin
          ctl.op     = OP_SM_DIV;
          state_next = ST_SM_WAIT;
        end
      end
      ST_SM_WAIT: begin
        if (stat.div_done) begin
          state_next = ST_SM_SET;
        end
      end
      ST_SM_SET: begin
        ctl.op     = OP_SM_SET;
        state_next = ST_SEP_SCL;
      end
      ST_SEP_SCL: begin
        ctl.op     = OP_SEP_SCL;
        state_next = ST_COH_SCL;
      end
      ST_COH_SCL: begin
        ctl.op     = OP_COH_SCL;
        state_next = ST_ACC;
      end
      ST_ACC: begin
        ctl.op     = OP_ACC;
        state_next = ST_VEL_SCL;
      end
      ST_VEL_SCL: begin
        ctl.op     = OP_VEL_SCL;
        state_next = ST_VEL;
      end
      ST_VEL: begin
        ctl.op     = OP_VEL;
        state_next = ST_POS_SCL;
      end
      ST_POS_SCL: begin
        ctl.op     = OP_POS_SCL;
        state_next = ST_POS;
      end
      ST_POS: begin
        ctl.op     = OP_POS;
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        ctl.op   = OP_EMIT;
        ctl.addr = i;
        ctl.last = i_last;
        if (i_last) begin
          j_next     = '0;
          state_next = ST_CP_RD;
        end else begin
          i_next     = i + 6'd1;
          state_next = ST_OWN_RD;
        end
      end
      ST_CP_RD: state_next = ST_CP_WR;
      ST_CP_WR: begin
        ctl.op = OP_COPY;
        if (j_last) begin
          state_next = ST_IDLE;
        end else begin
          j_next     = j + 6'd1;
          state_next = ST_CP_RD;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

// ===== sv/boids_flock_step_unit.sv =====
// ----------------------------------------------------------------------------
// boids_flock_step_unit
// Boid flock engine: load items fill the flock store, a step item updates
// every boid in signed Q16.16 and emits one result per boid.
// ----------------------------------------------------------------------------
// A load item (mode 0) is written to the flock store while busy stays low
// and gives no result. A step item (mode 1) keeps busy high until the
// store has been written back. Every pair of boids is checked in turn on the
// single read port of the flock store; each neighbor pair adds a serial
// divide of 33 quotient bits, and each boid with neighbors adds a divide for
// its mean. The two flock means are divided up front. Results come out in
// index order, each on the result port for exactly one cycle with
// result_valid high; the receiver cannot stall them and must take each one
// as it appears. The store is written back from the snapshot after the last
// result.
// ----------------------------------------------------------------------------
module boids_flock_step_unit
  import bfs_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  bfs_in_t     cmd,
  output logic        result_valid,
  output bfs_out_t    result,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  bfs_cfg_t   cfg;
  logic [6:0] flock_size;
  logic       cfg_wr;
  bfs_cmd_t   ctl;
  bfs_stat_t  stat;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      flock_size          <= RST_FLOCK_SIZE;
      cfg.neighbor_radius <= RST_RADIUS;
      cfg.time_step       <= RST_TIME_STEP;
      cfg.cohesion_gain   <= RST_COH_GAIN;
      cfg.separation_gain <= RST_SEP_GAIN;
      cfg.alignment_gain  <= RST_ALIGN_GAIN;
    end else if (cfg_wr) begin
      case (paddr[4:2])
        REG_FLOCK_SIZE: flock_size          <= pwdata[6:0];
        REG_RADIUS:     cfg.neighbor_radius <= pwdata[30:0];
        REG_TIME_STEP:  cfg.time_step       <= pwdata[15:0];
        REG_COH_GAIN:   cfg.cohesion_gain   <= pwdata[15:0];
        REG_SEP_GAIN:   cfg.separation_gain <= pwdata[15:0];
        REG_ALIGN_GAIN: cfg.alignment_gain  <= pwdata[15:0];
        default:        flock_size          <= flock_size;
      endcase
    end
  end

  // register readback
  always_comb begin
    case (paddr[4:2])
      REG_FLOCK_SIZE: prdata = {25'b0, flock_size};
      REG_RADIUS:     prdata = {1'b0, cfg.neighbor_radius};
      REG_TIME_STEP:  prdata = {16'b0, cfg.time_step};
      REG_COH_GAIN:   prdata = {16'b0, cfg.cohesion_gain};
      REG_SEP_GAIN:   prdata = {16'b0, cfg.separation_gain};
      REG_ALIGN_GAIN: prdata = {16'b0, cfg.alignment_gain};
      default:        prdata = '0;
    endcase
  end

  bfs_ctrl u_ctrl (
    .clk(clk), .rst(rst), .start(start), .mode(cmd.mode),
    .flock_size(flock_size), .stat(stat), .ctl(ctl), .busy(busy)
  );

  bfs_datapath u_dp (
    .clk(clk), .rst(rst), .ctl(ctl), .cmd_in(cmd), .cfg(cfg), .stat(stat),
    .result_valid(result_valid), .result(result)
  );

endmodule
